// ----- hw/rtl/svpwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants, ROM tables and helper functions of the
// space vector pwm duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int ANGLE_W   = 9;
    localparam int EFFORT_W  = 8;
    localparam int STEP_W    = 10;
    localparam int DUTY_W    = 8;
    localparam int SECTOR_W  = 3;
    localparam int OFFSET_W  = 6;
    localparam int PHASES    = 3;
    localparam int TABLE_LEN = 61;
    localparam int ANGLE_MOD = 360;
    localparam int SECTOR_SPAN = 60;
    localparam int SUM_W     = 11;
    localparam int PROD_W    = 16;

    // work queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // apb register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    typedef logic [ANGLE_W-1:0]         t_angle;
    typedef logic [EFFORT_W-1:0]        t_effort;
    typedef logic signed [STEP_W-1:0]   t_step;
    typedef logic [DUTY_W-1:0]          t_duty;
    typedef logic [SECTOR_W-1:0]        t_sector;
    typedef logic [OFFSET_W-1:0]        t_offset;
    typedef logic [PROD_W-1:0]          t_prod;
    typedef logic [1:0]                 t_pick;
    typedef logic [2*PHASES-1:0]        t_pick_row;
    typedef logic [APB_ADDR_W-1:0]      t_apb_addr;
    typedef logic [APB_DATA_W-1:0]      t_apb_data;

    typedef struct packed {
        t_angle  angle;
        t_sector sector;
        t_offset offset;
    } t_work;

    // register indexes
    localparam logic REG_EFFORT = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    localparam t_effort EFFORT_RESET = 8'd255;
    localparam t_duty   DUTY_MAX     = 8'd255;

    // pick codes: bit0 selects secondary table, bit1 takes the complement
    localparam t_pick PICK_PRI     = 2'd0;
    localparam t_pick PICK_SEC     = 2'd1;
    localparam t_pick PICK_PRI_CPL = 2'd2;
    localparam t_pick PICK_SEC_CPL = 2'd3;
    localparam int PICK_SEC_BIT = 0;
    localparam int PICK_CPL_BIT = 1;

    localparam t_duty PRIMARY_TABLE [TABLE_LEN] = '{
        8'd237, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd243, 8'd244, 8'd245, 8'd246,
        8'd247, 8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252,
        8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255,
        8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253,
        8'd252, 8'd252, 8'd251, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd248, 8'd247,
        8'd246, 8'd245, 8'd244, 8'd243, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239, 8'd237
    };

    localparam t_duty SECONDARY_TABLE [TABLE_LEN] = '{
        8'd17,  8'd19,  8'd21,  8'd24,  8'd27,  8'd29,  8'd32,  8'd35,  8'd38,  8'd42,
        8'd45,  8'd49,  8'd52,  8'd56,  8'd59,  8'd63,  8'd67,  8'd71,  8'd75,  8'd79,
        8'd83,  8'd88,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd114, 8'd118, 8'd123,
        8'd127,
        8'd131, 8'd136, 8'd140, 8'd145, 8'd149, 8'd154, 8'd158, 8'd162, 8'd166, 8'd171,
        8'd175, 8'd179, 8'd183, 8'd187, 8'd191, 8'd195, 8'd198, 8'd202, 8'd205, 8'd209,
        8'd212, 8'd216, 8'd219, 8'd222, 8'd225, 8'd227, 8'd230, 8'd233, 8'd235, 8'd237
    };

    // pick codes of phases c, b, a for one sector
    function automatic t_pick_row sector_pick(input t_sector s);
        t_pick_row row;
        case (s)
            3'd0:    row = {PICK_PRI_CPL, PICK_SEC,     PICK_PRI};
            3'd1:    row = {PICK_PRI_CPL, PICK_PRI,     PICK_SEC_CPL};
            3'd2:    row = {PICK_SEC,     PICK_PRI,     PICK_PRI_CPL};
            3'd3:    row = {PICK_PRI,     PICK_SEC_CPL, PICK_PRI_CPL};
            3'd4:    row = {PICK_PRI,     PICK_PRI_CPL, PICK_SEC};
            default: row = {PICK_SEC_CPL, PICK_PRI_CPL, PICK_PRI};
        endcase
        return row;
    endfunction

    function automatic t_sector angle_sector(input t_angle a);
        t_sector s;
        if (a >= ANGLE_W'(5 * SECTOR_SPAN))      s = 3'd5;
        else if (a >= ANGLE_W'(4 * SECTOR_SPAN)) s = 3'd4;
        else if (a >= ANGLE_W'(3 * SECTOR_SPAN)) s = 3'd3;
        else if (a >= ANGLE_W'(2 * SECTOR_SPAN)) s = 3'd2;
        else if (a >= ANGLE_W'(SECTOR_SPAN))     s = 3'd1;
        else                                     s = 3'd0;
        return s;
    endfunction

    function automatic t_angle sector_base(input t_sector s);
        t_angle b;
        case (s)
            3'd0:    b = ANGLE_W'(0);
            3'd1:    b = ANGLE_W'(SECTOR_SPAN);
            3'd2:    b = ANGLE_W'(2 * SECTOR_SPAN);
            3'd3:    b = ANGLE_W'(3 * SECTOR_SPAN);
            3'd4:    b = ANGLE_W'(4 * SECTOR_SPAN);
            default: b = ANGLE_W'(5 * SECTOR_SPAN);
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/svpwm_tick_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_tick_if
// Valid/ready channel carrying pwm period ticks.
// ----------------------------------------------------------------------------
interface svpwm_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svpwm_duty_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_duty_if
// Valid/ready channel carrying the angle and three phase compare values.
// ----------------------------------------------------------------------------
interface svpwm_duty_if;
    import svpwm_pkg::*;
    logic   valid;
    logic   ready;
    t_angle electrical_angle;
    t_duty  phase_a_duty;
    t_duty  phase_b_duty;
    t_duty  phase_c_duty;

    modport source (output valid, output electrical_angle, output phase_a_duty,
                    output phase_b_duty, output phase_c_duty, input ready);
    modport sink   (input valid, input electrical_angle, input phase_a_duty,
                    input phase_b_duty, input phase_c_duty, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svpwm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_front
// Accepts ticks, advances the electrical angle and classifies it into
// sector and offset for the work queue.
// ----------------------------------------------------------------------------
module svpwm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    svpwm_tick_if.sink         i_tick_ch,
    input  svpwm_pkg::t_step   i_step_angle,
    input  logic               i_q_full,
    output logic               o_push,
    output svpwm_pkg::t_work   o_work
);
    import svpwm_pkg::*;

    localparam logic signed [SUM_W-1:0] MOD_S = SUM_W'(ANGLE_MOD);

    t_angle                   r_angle;
    t_angle                   n_angle;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  wrapped;
    t_sector                  sector;
    logic                     accept;

    assign i_tick_ch.ready = !i_q_full;
    assign accept = i_tick_ch.valid && !i_q_full;
    assign o_push = accept && i_tick_ch.tick;

    // sum spans -512..870, so two corrections each way reach 0..359
    always_comb begin
        sum = $signed({2'b00, r_angle}) + SUM_W'(i_step_angle);
        wrapped = sum;
        if (wrapped < 0) wrapped = wrapped + MOD_S;
        if (wrapped < 0) wrapped = wrapped + MOD_S;
        if (wrapped >= MOD_S) wrapped = wrapped - MOD_S;
        if (wrapped >= MOD_S) wrapped = wrapped - MOD_S;
        n_angle = wrapped[ANGLE_W-1:0];
        sector = angle_sector(n_angle);
    end

    always_comb begin
        o_work.angle  = n_angle;
        o_work.sector = sector;
        o_work.offset = OFFSET_W'(n_angle - sector_base(sector));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (o_push) begin
            r_angle <= n_angle;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/svpwm_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_fifo
// Short work queue between the angle front end and the duty back end.
// ----------------------------------------------------------------------------
module svpwm_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  svpwm_pkg::t_work   i_work,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output svpwm_pkg::t_work   o_work
);
    import svpwm_pkg::*;

    t_work                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/svpwm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_back
// Two-stage duty pipeline: table pick and effort product, then divide by
// 255 and centring into the output register.
// ----------------------------------------------------------------------------
module svpwm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  svpwm_pkg::t_work   i_work,
    output logic               o_pop,
    input  svpwm_pkg::t_effort i_effort,
    svpwm_duty_if.source       o_duty_ch
);
    import svpwm_pkg::*;

    t_prod      r_s1_prod [PHASES];
    t_angle     r_s1_angle;
    logic       r_s1_vld;
    t_duty      r_out_duty [PHASES];
    t_angle     r_out_angle;
    logic       r_out_vld;

    t_pick_row  pick_row;
    t_prod      n_prod [PHASES];
    t_duty      n_duty [PHASES];
    t_duty      center;
    logic       out_adv;
    logic       s1_adv;

    assign out_adv = !r_out_vld || o_duty_ch.ready;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_pop   = s1_adv;
    assign center  = (DUTY_MAX - i_effort) >> 1;

    always_comb begin
        t_pick pick;
        t_duty v;
        pick_row = sector_pick(i_work.sector);
        for (int p = 0; p < PHASES; p++) begin
            pick = pick_row[2*p +: 2];
            v = pick[PICK_SEC_BIT] ? SECONDARY_TABLE[i_work.offset]
                                   : PRIMARY_TABLE[i_work.offset];
            if (pick[PICK_CPL_BIT]) v = DUTY_MAX - v;
            n_prod[p] = PROD_W'(v) * PROD_W'(i_effort);
        end
    end

    // x/255 == ((x+1)*257) >> 16 over the product range
    always_comb begin
        logic [PROD_W:0]     inc;
        logic [PROD_W+8:0]   scaled;
        logic [DUTY_W:0]     total;
        for (int p = 0; p < PHASES; p++) begin
            inc    = {1'b0, r_s1_prod[p]} + 1'b1;
            scaled = {inc, 8'b0} + {8'b0, inc};
            total  = {1'b0, scaled[PROD_W+7:PROD_W]} + {1'b0, center};
            n_duty[p] = total[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_prod  <= n_prod;
            r_s1_angle <= i_work.angle;
        end
        if (out_adv) begin
            r_out_duty  <= n_duty;
            r_out_angle <= r_s1_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv)  r_s1_vld  <= i_valid;
            if (out_adv) r_out_vld <= r_s1_vld;
        end
    end

    assign o_duty_ch.valid            = r_out_vld;
    assign o_duty_ch.electrical_angle = r_out_angle;
    assign o_duty_ch.phase_a_duty     = r_out_duty[0];
    assign o_duty_ch.phase_b_duty     = r_out_duty[1];
    assign o_duty_ch.phase_c_duty     = r_out_duty[2];

endmodule
`default_nettype wire

// ----- hw/rtl/space_vector_pwm_duty_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_generator_core
// Space vector pwm duty generator: angle accumulator, sector lookup and
// effort scaling for a three-phase bridge.
// ----------------------------------------------------------------------------
// usage
// - i_tick_ch takes one item per pwm period; each item with tick set adds
//   step_angle to the electrical angle, wraps it into 0..359 and yields one
//   item on o_duty_ch with the new angle and the phase a, b, c compare values
// - the apb port holds effort (address 0) and step_angle (address 4); write
//   them only while no item is in flight
// - each item passes the work queue, then the stage-one and output registers
// - throughput: one item per cycle while the receiver does not stall, set by the
//   angle update in the front end; the back end is a two-stage pipeline behind a
//   two-entry work queue
// - when the receiver stalls, the output register holds its item, the back
//   end fills up, and ready on i_tick_ch drops once the queue is full
// - reset clears the angle to zero, effort to 255, step_angle to zero and
//   empties the queue and pipeline
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_generator_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    svpwm_tick_if.sink             i_tick_ch,
    svpwm_duty_if.source           o_duty_ch,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  svpwm_pkg::t_apb_addr   paddr,
    input  svpwm_pkg::t_apb_data   pwdata,
    output svpwm_pkg::t_apb_data   prdata,
    output logic                   pready
);
    import svpwm_pkg::*;

    t_effort  r_effort;
    t_step    r_step;
    logic     reg_sel;
    logic     wr_en;

    logic     q_full;
    logic     q_push;
    t_work    q_in;
    logic     q_valid;
    t_work    q_out;
    logic     q_pop;

    assign pready  = 1'b1;
    assign reg_sel = paddr[REG_SEL_BIT];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effort <= EFFORT_RESET;
            r_step   <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_EFFORT: r_effort <= pwdata[EFFORT_W-1:0];
                REG_STEP:   r_step   <= pwdata[STEP_W-1:0];
                default:    r_effort <= r_effort;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_EFFORT: prdata = APB_DATA_W'(r_effort);
            REG_STEP:   prdata = APB_DATA_W'(r_step);
            default:    prdata = '0;
        endcase
    end

    svpwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_ch    (i_tick_ch),
        .i_step_angle (r_step),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_work       (q_in)
    );

    svpwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_work  (q_out)
    );

    svpwm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_work    (q_out),
        .o_pop     (q_pop),
        .i_effort  (r_effort),
        .o_duty_ch (o_duty_ch)
    );

endmodule
`default_nettype wire

// ----- tb/svpwm_duty_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_duty_checker
// Watches the tick channel, the duty channel and apb writes of the space
// vector pwm duty generator. It keeps its own angle, effort and step, works
// out the angle and three compare values for every accepted tick, and
// compares each accepted duty item field by field against the oldest one.
// ----------------------------------------------------------------------------
module svpwm_duty_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_ready,
    input  logic                 i_tick,
    input  logic                 i_duty_valid,
    input  logic                 i_duty_ready,
    input  svpwm_pkg::t_angle    i_electrical_angle,
    input  svpwm_pkg::t_duty     i_phase_a_duty,
    input  svpwm_pkg::t_duty     i_phase_b_duty,
    input  svpwm_pkg::t_duty     i_phase_c_duty,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  svpwm_pkg::t_apb_addr i_paddr,
    input  svpwm_pkg::t_apb_data i_pwdata,
    output int                   o_mismatches,
    output int                   o_outstanding
);
    import svpwm_pkg::*;

    localparam int SECTORS    = ANGLE_MOD / SECTOR_SPAN;
    localparam int FULL_SCALE = 255;

    typedef struct {
        t_angle angle;
        t_duty  a;
        t_duty  b;
        t_duty  c;
    } t_duty_set;

    // table choice of phases a, b, c per sector
    localparam t_pick SECTOR_PICKS [SECTORS][PHASES] = '{
        '{PICK_PRI,     PICK_SEC,     PICK_PRI_CPL},
        '{PICK_SEC_CPL, PICK_PRI,     PICK_PRI_CPL},
        '{PICK_PRI_CPL, PICK_PRI,     PICK_SEC},
        '{PICK_PRI_CPL, PICK_SEC_CPL, PICK_PRI},
        '{PICK_SEC,     PICK_PRI_CPL, PICK_PRI},
        '{PICK_PRI,     PICK_PRI_CPL, PICK_SEC_CPL}
    };

    t_angle    angle_acc;
    t_effort   effort_q;
    t_step     step_q;
    t_duty_set pending_duty_sets [$];
    int        fail_total;

    function automatic t_duty phase_compare(input t_pick pick, input int k,
                                            input t_effort eff);
        int unsigned v;
        int unsigned e;
        e = eff;
        v = pick[PICK_SEC_BIT] ? SECONDARY_TABLE[k] : PRIMARY_TABLE[k];
        if (pick[PICK_CPL_BIT]) begin
            v = FULL_SCALE - v;
        end
        return t_duty'((v * e) / FULL_SCALE + (FULL_SCALE - e) / 2);
    endfunction

    function automatic t_duty_set next_duty_set(input t_angle angle_now,
                                                input t_step stp,
                                                input t_effort eff);
        t_duty_set r;
        int sum;
        int sector;
        int k;
        sum = int'(angle_now) + int'(stp);
        sum = sum % ANGLE_MOD;
        if (sum < 0) begin
            sum += ANGLE_MOD;
        end
        sector = sum / SECTOR_SPAN;
        k = sum - sector * SECTOR_SPAN;
        r.angle = t_angle'(sum);
        r.a = phase_compare(SECTOR_PICKS[sector][0], k, eff);
        r.b = phase_compare(SECTOR_PICKS[sector][1], k, eff);
        r.c = phase_compare(SECTOR_PICKS[sector][2], k, eff);
        return r;
    endfunction

    task automatic report_field(input string fname, input int want, input int got);
        if (want != got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_duty_set want;
        int        reg_idx;
        if (!i_rst_n) begin
            angle_acc = '0;
            effort_q  = EFFORT_RESET;
            step_q    = '0;
            pending_duty_sets.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = int'(i_paddr >> REG_SEL_BIT);
                if (reg_idx == int'(REG_EFFORT)) begin
                    effort_q = i_pwdata[EFFORT_W-1:0];
                end else if (reg_idx == int'(REG_STEP)) begin
                    step_q = i_pwdata[STEP_W-1:0];
                end
            end
            if (i_tick_valid && i_tick_ready && i_tick) begin
                want = next_duty_set(angle_acc, step_q, effort_q);
                angle_acc = want.angle;
                pending_duty_sets.push_back(want);
            end
            if (i_duty_valid && i_duty_ready) begin
                if (pending_duty_sets.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected item, expected none, got angle %0d",
                             $time, i_electrical_angle);
                end else begin
                    want = pending_duty_sets.pop_front();
                    report_field("electrical_angle", want.angle, i_electrical_angle);
                    report_field("phase_a_duty", want.a, i_phase_a_duty);
                    report_field("phase_b_duty", want.b, i_phase_b_duty);
                    report_field("phase_c_duty", want.c, i_phase_c_duty);
                end
            end
        end
        o_mismatches  <= fail_total;
        o_outstanding <= pending_duty_sets.size();
    end

endmodule

// ----- tb/tb_space_vector_pwm_duty_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_duty_generator_core
// Drives ticks and apb register writes into the duty generator, stalls the
// duty channel at random, and gives the verdict from the checker's count.
// A directed walk over sectors, step extremes and effort extremes comes
// first, then randomized phases of effort and step settings.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_duty_generator_core;
    import svpwm_pkg::*;

    localparam int ITEM_TARGET    = 650;
    localparam int HOLD_LEN       = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam t_apb_addr ADDR_EFFORT = t_apb_addr'(4 * int'(REG_EFFORT));
    localparam t_apb_addr ADDR_STEP   = t_apb_addr'(4 * int'(REG_STEP));

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      psel;
    logic      penable;
    logic      pwrite;
    t_apb_addr paddr;
    t_apb_data pwdata;
    t_apb_data prdata;
    logic      pready;

    int       mismatches;
    int       pending;
    int       ticks_sent = 0;
    int       burst_left = 0;
    int       gap_max = 0;
    logic     hold_start;
    int       hold_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       idle_cycles = 0;

    svpwm_tick_if tick_ch();
    svpwm_duty_if duty_ch();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    space_vector_pwm_duty_generator_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick_ch (tick_ch),
        .o_duty_ch (duty_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    svpwm_duty_checker u_duty_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick_valid       (tick_ch.valid),
        .i_tick_ready       (tick_ch.ready),
        .i_tick             (tick_ch.tick),
        .i_duty_valid       (duty_ch.valid),
        .i_duty_ready       (duty_ch.ready),
        .i_electrical_angle (duty_ch.electrical_angle),
        .i_phase_a_duty     (duty_ch.phase_a_duty),
        .i_phase_b_duty     (duty_ch.phase_b_duty),
        .i_phase_c_duty     (duty_ch.phase_c_duty),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_mismatches       (mismatches),
        .o_outstanding      (pending)
    );

    // receiver: random stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            duty_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            duty_ch.ready <= 1'b0;
        end else if (hold_start) begin
            hold_left = HOLD_LEN;
            duty_ch.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(5, 60);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   duty_ch.ready <= 1'b1;
                RX_MOSTLY: duty_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: duty_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   duty_ch.ready <= ~duty_ch.ready;
            endcase
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((tick_ch.valid && tick_ch.ready) || (duty_ch.valid && duty_ch.ready) ||
                (psel && penable && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic tk);
        int gap;
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tk;
        do @(posedge i_clk); while (!tick_ch.ready);
        if (tk) begin
            ticks_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                tick_ch.valid <= 1'b0;
                tick_ch.tick  <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // sender pause until every result is back, then let the pipe settle
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_apb_addr addr, input t_apb_data data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_effort eff, input t_step stp, input int n,
                             input bit with_hold, input bit noisy);
        t_apb_data upper;
        upper = noisy ? t_apb_data'($urandom) : '0;
        apb_write(ADDR_EFFORT, {upper[APB_DATA_W-1:EFFORT_W], eff});
        apb_write(ADDR_STEP, {upper[APB_DATA_W-1:STEP_W], stp});
        if (with_hold) begin
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            send_tick(noisy ? ($urandom_range(0, 9) != 0) : 1'b1);
        end
        drain();
    endtask

    initial begin
        t_effort eff;
        int      s;
        int      n;
        bit      hold_done;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tick_ch.valid = 1'b0;
        tick_ch.tick  = 1'b0;
        duty_ch.ready = 1'b0;
        hold_start    = 1'b0;
        hold_done     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: step zero keeps the angle at zero, idle tick does nothing
        gap_max = 2;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();
        // one full turn in sector steps, then step and effort extremes
        run_phase(8'd255, 10'sd60, 6, 1'b0, 1'b0);
        run_phase(8'd255, -10'sd359, 2, 1'b0, 1'b0);
        run_phase(8'd255, 10'sd359, 2, 1'b0, 1'b0);
        run_phase(8'd0, -10'sd60, 3, 1'b0, 1'b0);
        run_phase(8'd1, 10'sd59, 3, 1'b0, 1'b0);
        // steps past a full turn wrap modulo 360
        run_phase(8'd254, -10'sd512, 2, 1'b0, 1'b0);
        run_phase(8'd128, 10'sd511, 2, 1'b0, 1'b0);

        while (ticks_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       eff = 8'd0;
                1:       eff = 8'd255;
                2:       eff = 8'($urandom_range(1, 4));
                default: eff = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       s = $urandom_range(0, 1) ? 359 : -359;
                1:       s = int'($urandom_range(0, 10)) - 5;
                2:       s = $urandom_range(0, 1) ? int'($urandom_range(360, 511))
                                                  : -int'($urandom_range(360, 512));
                default: s = int'($urandom_range(0, 718)) - 359;
            endcase
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            n = $urandom_range(10, 50);
            if (!hold_done && ticks_sent >= ITEM_TARGET / 3) begin
                // sender keeps offering while the receiver holds off
                hold_done = 1'b1;
                gap_max = 0;
                n = 40;
                run_phase(eff, t_step'(s), n, 1'b1, 1'b1);
            end else begin
                run_phase(eff, t_step'(s), n, 1'b0, 1'b1);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
